@@ hdl/pdr_pkg.sv @@
// Shared types and constants for the palette deduplication and remap block.
// Used by palette_dedup_remap; depends on nothing else.
package pdr_pkg;

  localparam int COLOR_W = 32;
  localparam int NIDX_W  = 8;
  localparam int CNT_W   = 9;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_MARK  = 3'd1,
    OP_BUILD = 3'd2,
    OP_REMAP = 3'd3,
    OP_READ  = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNUSED    = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_NEXT,
    FSM_COLOR,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  // One source entry: its RGBA color and the compact index that build assigns to it.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [NIDX_W-1:0]  remap;
  } entry_t;

endpackage

@@ hdl/pdr_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module pdr_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ hdl/palette_dedup_remap.sv @@
// Top level of the palette deduplication and remap block.
// Depends on pdr_pkg (types, codes) and pdr_ram (entry and compact palette memories).
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_ready_o | operation_i, index_i, red/green/blue/alpha_i
//   out     | output    | out_valid_o/out_ready_i | new_index_o, out_*_o, counts, status_o
//
// Load, mark and clear take effect when accepted; a remap or read result passes through
// the memory read in the read stage, then the output register.
// Build walks all PALETTE_ENTRIES indices in order: an unused index is skipped, a used index
// reads its color and then compares it against the compact entries found so far, one at a
// time. Reset clears the used map, the counts and the built flag at once.
// While build runs, or while a result waits in the read stage and the output register
// cannot take it, in_ready_o is low.
module palette_dedup_remap #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] new_index_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic [8:0] unique_count_o,
  output logic [8:0] translucent_count_o,
  output logic [1:0] status_o
);

  localparam int IW      = $clog2(PALETTE_ENTRIES);
  localparam int CW      = $clog2(PALETTE_ENTRIES + 1);
  localparam int NIDX_W  = pdr_pkg::NIDX_W;
  localparam int CNT_W   = pdr_pkg::CNT_W;
  localparam int COLOR_W = pdr_pkg::COLOR_W;
  localparam int ENTRY_W = $bits(pdr_pkg::entry_t);

  // Build sequencer and bookkeeping.
  pdr_pkg::fsm_e        state_q, state_d;
  logic [CW-1:0]        bi_q, bi_d;
  logic [IW-1:0]        k_q, k_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic [CNT_W-1:0]     distinct_q, distinct_d;
  logic [CNT_W-1:0]     trans_q, trans_d;
  logic                 built_q, built_d;
  logic [PALETTE_ENTRIES-1:0] used_q, used_d;

  // Memory read stage for remap and read transactions.
  logic                 s1_valid_q, s1_valid_d;
  pdr_pkg::op_e         s1_op_q, s1_op_d;
  pdr_pkg::status_e     s1_status_q, s1_status_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [NIDX_W-1:0]    out_nidx_q, out_nidx_d;
  logic [COLOR_W-1:0]   out_color_q, out_color_d;
  logic [CNT_W-1:0]     out_uniq_q, out_uniq_d;
  logic [CNT_W-1:0]     out_trans_q, out_trans_d;
  pdr_pkg::status_e     out_status_q, out_status_d;

  // Memory ports.
  logic                 a_we, a_re, b_we, b_re;
  logic [IW-1:0]        a_waddr, a_raddr, b_waddr, b_raddr;
  pdr_pkg::entry_t      a_wdata, a_rdata;
  logic [COLOR_W-1:0]   b_wdata, b_rdata;

  logic                 accept, out_free, in_range, used_hit;
  logic                 new_en;
  logic [COLOR_W-1:0]   new_color;
  pdr_pkg::op_e         op;

  // Entry memory: source color plus the remap result, indexed by palette index.
  pdr_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (a_we),
    .wr_addr_i (a_waddr),
    .wr_data_i (a_wdata),
    .rd_en_i   (a_re),
    .rd_addr_i (a_raddr),
    .rd_data_o (a_rdata)
  );

  // Compact palette memory, indexed by new index.
  pdr_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (COLOR_W)
  ) u_compact_ram (
    .clk_i     (clk_i),
    .wr_en_i   (b_we),
    .wr_addr_i (b_waddr),
    .wr_data_i (b_wdata),
    .rd_en_i   (b_re),
    .rd_addr_i (b_raddr),
    .rd_data_o (b_rdata)
  );

  assign op       = pdr_pkg::op_e'(operation_i);
  assign out_free = !out_valid_q || out_ready_i;
  // A new transaction may enter only while idle and when the read stage can move on.
  assign in_ready_o = (state_q == pdr_pkg::FSM_IDLE) && (!s1_valid_q || out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, index_i} < CNT_W'(PALETTE_ENTRIES);
  assign used_hit   = in_range ? used_q[index_i[IW-1:0]] : 1'b0;

  always_comb begin
    state_d      = state_q;
    bi_d         = bi_q;
    k_d          = k_q;
    color_d      = color_q;
    distinct_d   = distinct_q;
    trans_d      = trans_q;
    built_d      = built_q;
    used_d       = used_q;
    s1_valid_d   = s1_valid_q;
    s1_op_d      = s1_op_q;
    s1_status_d  = s1_status_q;
    out_valid_d  = out_valid_q;
    out_nidx_d   = out_nidx_q;
    out_color_d  = out_color_q;
    out_uniq_d   = out_uniq_q;
    out_trans_d  = out_trans_q;
    out_status_d = out_status_q;
    a_we         = 1'b0;
    a_waddr      = '0;
    a_wdata      = '0;
    a_re         = 1'b0;
    a_raddr      = '0;
    b_we         = 1'b0;
    b_waddr      = '0;
    b_wdata      = '0;
    b_re         = 1'b0;
    b_raddr      = '0;
    new_en       = 1'b0;
    new_color    = '0;

    // Output side: the read stage has priority, then a finished build, else drain.
    if (s1_valid_q && out_free) begin
      s1_valid_d   = 1'b0;
      out_valid_d  = 1'b1;
      out_status_d = s1_status_q;
      out_uniq_d   = distinct_q;
      out_trans_d  = trans_q;
      out_nidx_d   = ((s1_op_q == pdr_pkg::OP_REMAP) && (s1_status_q == pdr_pkg::ST_OK))
                     ? a_rdata.remap : '0;
      out_color_d  = ((s1_op_q == pdr_pkg::OP_READ) && (s1_status_q == pdr_pkg::ST_OK))
                     ? b_rdata : '0;
    end else if ((state_q == pdr_pkg::FSM_DONE) && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = pdr_pkg::ST_OK;
      out_uniq_d   = distinct_q;
      out_trans_d  = trans_q;
      out_nidx_d   = '0;
      out_color_d  = '0;
      built_d      = 1'b1;
      state_d      = pdr_pkg::FSM_IDLE;
    end else if (out_ready_i) begin
      out_valid_d  = 1'b0;
    end

    // Input transactions; accept implies the sequencer is idle.
    if (accept) begin
      unique case (op)
        pdr_pkg::OP_LOAD: begin
          if (in_range) begin
            a_we    = 1'b1;
            a_waddr = index_i[IW-1:0];
            a_wdata = '{color: {red_i, green_i, blue_i, alpha_i}, remap: '0};
          end
          built_d = 1'b0;
        end
        pdr_pkg::OP_MARK: begin
          if (in_range) begin
            used_d[index_i[IW-1:0]] = 1'b1;
          end
          built_d = 1'b0;
        end
        pdr_pkg::OP_CLEAR: begin
          used_d  = '0;
          built_d = 1'b0;
        end
        pdr_pkg::OP_BUILD: begin
          distinct_d = '0;
          trans_d    = '0;
          bi_d       = '0;
          built_d    = 1'b0;
          state_d    = pdr_pkg::FSM_NEXT;
        end
        pdr_pkg::OP_REMAP: begin
          a_re       = 1'b1;
          a_raddr    = index_i[IW-1:0];
          s1_valid_d = 1'b1;
          s1_op_d    = pdr_pkg::OP_REMAP;
          if (!built_q) begin
            s1_status_d = pdr_pkg::ST_NOT_BUILT;
          end else if (!used_hit) begin
            s1_status_d = pdr_pkg::ST_UNUSED;
          end else begin
            s1_status_d = pdr_pkg::ST_OK;
          end
        end
        pdr_pkg::OP_READ: begin
          b_re       = 1'b1;
          b_raddr    = index_i[IW-1:0];
          s1_valid_d = 1'b1;
          s1_op_d    = pdr_pkg::OP_READ;
          if (!built_q) begin
            s1_status_d = pdr_pkg::ST_NOT_BUILT;
          end else if ({1'b0, index_i} >= distinct_q) begin
            s1_status_d = pdr_pkg::ST_UNUSED;
          end else begin
            s1_status_d = pdr_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
    end

    // Build sequencer. A used index reads its color, then compares it against the
    // compact entries found so far, one per cycle. The first match gives its new index;
    // no match appends the color as a new compact entry.
    unique case (state_q)
      pdr_pkg::FSM_IDLE: begin
      end
      pdr_pkg::FSM_NEXT: begin
        if (bi_q == CW'(PALETTE_ENTRIES)) begin
          state_d = pdr_pkg::FSM_DONE;
        end else if (used_q[bi_q[IW-1:0]]) begin
          a_re    = 1'b1;
          a_raddr = bi_q[IW-1:0];
          state_d = pdr_pkg::FSM_COLOR;
        end else begin
          bi_d = bi_q + 1'b1;
        end
      end
      pdr_pkg::FSM_COLOR: begin
        if (distinct_q == '0) begin
          new_en    = 1'b1;
          new_color = a_rdata.color;
        end else begin
          color_d = a_rdata.color;
          b_re    = 1'b1;
          b_raddr = '0;
          k_d     = '0;
          state_d = pdr_pkg::FSM_SCAN;
        end
      end
      pdr_pkg::FSM_SCAN: begin
        if (b_rdata == color_q) begin
          a_we    = 1'b1;
          a_waddr = bi_q[IW-1:0];
          a_wdata = '{color: color_q, remap: NIDX_W'(k_q)};
          bi_d    = bi_q + 1'b1;
          state_d = pdr_pkg::FSM_NEXT;
        end else if (CNT_W'(k_q) + 1'b1 == distinct_q) begin
          new_en    = 1'b1;
          new_color = color_q;
        end else begin
          b_re    = 1'b1;
          b_raddr = k_q + 1'b1;
          k_d     = k_q + 1'b1;
        end
      end
      pdr_pkg::FSM_DONE: begin
      end
      default: begin
        state_d = pdr_pkg::FSM_IDLE;
      end
    endcase

    // A color seen for the first time takes the next compact slot.
    if (new_en) begin
      a_we       = 1'b1;
      a_waddr    = bi_q[IW-1:0];
      a_wdata    = '{color: new_color, remap: NIDX_W'(distinct_q[IW-1:0])};
      b_we       = 1'b1;
      b_waddr    = distinct_q[IW-1:0];
      b_wdata    = new_color;
      distinct_d = distinct_q + 1'b1;
      if (new_color[7:0] != pdr_pkg::ALPHA_OPAQUE) begin
        trans_d = trans_q + 1'b1;
      end
      bi_d       = bi_q + 1'b1;
      state_d    = pdr_pkg::FSM_NEXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdr_pkg::FSM_IDLE;
      distinct_q  <= '0;
      trans_q     <= '0;
      built_q     <= 1'b0;
      used_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      distinct_q  <= distinct_d;
      trans_q     <= trans_d;
      built_q     <= built_d;
      used_q      <= used_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bi_q         <= bi_d;
    k_q          <= k_d;
    color_q      <= color_d;
    s1_op_q      <= s1_op_d;
    s1_status_q  <= s1_status_d;
    out_nidx_q   <= out_nidx_d;
    out_color_q  <= out_color_d;
    out_uniq_q   <= out_uniq_d;
    out_trans_q  <= out_trans_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o         = out_valid_q;
  assign new_index_o         = out_nidx_q;
  assign out_red_o           = out_color_q[31:24];
  assign out_green_o         = out_color_q[23:16];
  assign out_blue_o          = out_color_q[15:8];
  assign out_alpha_o         = out_color_q[7:0];
  assign unique_count_o      = out_uniq_q;
  assign translucent_count_o = out_trans_q;
  assign status_o            = out_status_q;

`ifndef SYNTHESIS
  // The read stage has always drained before the build sequencer is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pdr_pkg::FSM_IDLE) |-> !s1_valid_q)
    else $error("read stage busy during build");

  // Build never finds more distinct colors than there are palette entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_q <= CNT_W'(PALETTE_ENTRIES))
    else $error("distinct count beyond palette size");

  // Translucent colors are a subset of the distinct colors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trans_q <= distinct_q)
    else $error("translucent count exceeds distinct count");

  // Any transaction that changes the tables makes the last build stale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == pdr_pkg::OP_LOAD || op == pdr_pkg::OP_MARK ||
               op == pdr_pkg::OP_CLEAR) |=> !built_q)
    else $error("built flag survived a table change");
`endif

endmodule
